FILE: design/ecd_pkg.sv
// ecd_pkg: shared widths, field positions, register indexes and constants
// for the epoch-seconds to civil-date converter. No dependencies.
package ecd_pkg;

    // Stream and configuration widths
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 5;

    // Register stages from input to output register
    localparam int PIPE_DEPTH  = 14;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_OFFSET  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEEKDAY_MODE = 1'b1;

    // Result field layout in m_axis_tdata, lowest bit first
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int MDAY_W  = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 16;
    localparam int YDAY_W  = 9;
    localparam int WDAY_W  = 3;
    localparam int SEC_LSB   = 0;
    localparam int MIN_LSB   = SEC_LSB + SEC_W;
    localparam int HOUR_LSB  = MIN_LSB + MIN_W;
    localparam int MDAY_LSB  = HOUR_LSB + HOUR_W;
    localparam int MONTH_LSB = MDAY_LSB + MDAY_W;
    localparam int YEAR_LSB  = MONTH_LSB + MONTH_W;
    localparam int YDAY_LSB  = YEAR_LSB + YEAR_W;
    localparam int WDAY_LSB  = YDAY_LSB + YDAY_W;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd0;

    // Calendar constants
    localparam int SECS_PER_HOUR = 3600;
    localparam int DAYS_PER_ERA  = 146097;
    localparam int ERA_BIAS      = 40;
    // 1970-01-01 to 0000-03-01, plus whole eras to keep the sum positive
    localparam int Z_BIAS        = 719468 + DAYS_PER_ERA * ERA_BIAS;
    // weekday offset (epoch was a Thursday) plus a multiple of seven
    localparam int W_BIAS        = 4 + 7 * (2 ** 21);
    // day count split: seconds >> 7, then / 675 in two digit steps
    localparam int DAY_HI_ERAS   = 195;
    localparam int DAY_HI_BIAS   = 675 * DAY_HI_ERAS;

    // Reciprocals, ceil(2^k / d), k = numerator bits + ceil(log2 d)
    localparam logic [19:0] RCP_675_HI = 20'(((64'd1 << 29) + 64'd674) / 64'd675);
    localparam logic [26:0] RCP_675_LO = 27'(((64'd1 << 36) + 64'd674) / 64'd675);
    localparam logic [24:0] RCP_146097 = 25'(((64'd1 << 42) + 64'd146096) / 64'd146097);
    localparam logic [17:0] RCP_3600   = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
    localparam logic [12:0] RCP_60     = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
    localparam logic [25:0] RCP_7      = 26'(((64'd1 << 28) + 64'd6) / 64'd7);
    localparam logic [18:0] RCP_1460   = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam logic [18:0] RCP_36524  = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
    localparam logic [18:0] RCP_365    = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam logic [9:0]  RCP_100    = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
    localparam logic [11:0] RCP_153    = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

    // First day-of-year (March based) of shifted month mp: (153 * mp + 2) / 5
    function automatic logic [8:0] mp_start(input logic [3:0] mp);
        logic [8:0] d;
        unique case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

FILE: design/epoch_seconds_to_civil_date.sv
// epoch_seconds_to_civil_date: Unix seconds to local civil date and time.
// Top level; uses ecd_pkg for widths, field layout and reciprocal constants.

// Takes one signed 40-bit Unix seconds count per request and returns local
// time of day, proleptic Gregorian date, day of year and weekday. The zone
// offset register adds whole hours before conversion; the weekday mode
// register picks the weekday of the floored day count (0) or of the day count
// truncated towards zero (1). The block is a 14-stage pipeline: one request
// is taken every cycle while the output side does not stall. The depth is
// set by the chain of reciprocal multiplications (seconds to days in two
// digit steps, days to era, era to year, year to month), with a register
// after each stage. Every stage advances independently, so empty stages
// fill while the output waits, and s_axis_tready is high whenever
// m_axis_tready is.
// Configuration writes take effect at once and are meant for idle periods.
module epoch_seconds_to_civil_date (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [ecd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ecd_pkg::CFG_DATA_W-1:0]     cfg_data,
    // request channel
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ecd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [39:0] unix_seconds
    // result channel
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
    // [21:17] day_of_month, [25:22] month_index, [41:26] year_since_1900,
    // [50:42] day_of_year, [53:51] weekday, [55:54] zero
    output logic [ecd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import ecd_pkg::*;

    // ---------------- configuration ----------------
    logic signed [CFG_DATA_W-1:0] zone_offset_reg;
    logic                         weekday_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_offset_reg  <= '0;
            weekday_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ZONE_OFFSET:  zone_offset_reg  <= signed'(cfg_data);
                CFG_WEEKDAY_MODE: weekday_mode_reg <= cfg_data[0];
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // adv[i]: stage i+1 register may load this cycle
    logic [PIPE_DEPTH-1:0] v_reg, v_next, adv;

    always_comb begin
        adv[PIPE_DEPTH-1] = !v_reg[PIPE_DEPTH-1] || m_axis_tready;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
        v_next[0] = adv[0] ? s_axis_tvalid : v_reg[0];
        for (int i = 1; i < PIPE_DEPTH; i++) begin
            v_next[i] = adv[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = v_reg[PIPE_DEPTH-1];

    // ---------------- stage 1: apply zone offset ----------------
    logic signed [40:0] off_secs;
    logic signed [40:0] s1_t_next, s1_t_reg;

    always_comb begin
        off_secs  = 41'(zone_offset_reg) * 41'(SECS_PER_HOUR);
        s1_t_next = 41'(signed'(s_axis_tdata)) + off_secs;
    end

    // ---------------- stage 2: high digit of (t >> 7) / 675 ----------------
    // t >> 23 is biased by 195 * 675 so the division is unsigned
    logic [17:0] s2_h;
    logic [18:0] s2_x_next, s2_x_reg;
    logic [38:0] s2_prod;
    logic [8:0]  s2_a_next, s2_a_reg;
    logic [22:0] s2_tl_reg;
    logic        s2_neg_reg;

    always_comb begin
        s2_h      = s1_t_reg[40:23];
        s2_x_next = {s2_h[17], s2_h} + 19'(DAY_HI_BIAS);
        s2_prod   = 39'(s2_x_next) * 39'(RCP_675_HI);
        s2_a_next = s2_prod[37:29];
    end

    // ---------------- stage 3: high digit remainder ----------------
    logic [18:0] s3_bfull;
    logic [9:0]  s3_b_next, s3_b_reg;
    logic [8:0]  s3_a_reg;
    logic [22:0] s3_tl_reg;
    logic        s3_neg_reg;

    always_comb begin
        s3_bfull  = s2_x_reg - 19'(s2_a_reg) * 19'd675;
        s3_b_next = s3_bfull[9:0];
    end

    // ---------------- stage 4: low digit quotient ----------------
    logic [25:0] s4_y_next, s4_y_reg;
    logic [52:0] s4_prod;
    logic [15:0] s4_c_next, s4_c_reg;
    logic [8:0]  s4_a_reg;
    logic [6:0]  s4_tl7_reg;
    logic        s4_neg_reg;

    always_comb begin
        s4_y_next = {s3_b_reg, s3_tl_reg[22:7]};
        s4_prod   = 53'(s4_y_next) * 53'(RCP_675_LO);
        s4_c_next = s4_prod[51:36];
    end

    // ---------------- stage 5: day number and second of day ----------------
    logic [25:0]        s5_rfull;
    logic [9:0]         s5_hi;
    logic [16:0]        s5_sod_next, s5_sod_reg;
    logic signed [23:0] s5_days_next, s5_days_reg;
    logic signed [23:0] s5_tdays;
    logic signed [23:0] s5_wbase_next, s5_wbase_reg;

    always_comb begin
        s5_rfull      = s4_y_reg - 26'(s4_c_reg) * 26'd675;
        s5_sod_next   = {s5_rfull[9:0], s4_tl7_reg};
        s5_hi         = 10'(s4_a_reg) - 10'(DAY_HI_ERAS);
        s5_days_next  = signed'({s5_hi[7:0], s4_c_reg});
        // truncated count: one day later for negative time off midnight
        s5_tdays      = s5_days_next + 24'(s4_neg_reg && (s5_sod_next != '0));
        s5_wbase_next = weekday_mode_reg ? s5_tdays : s5_days_next;
    end

    // ---------------- stage 6: era, hour, weekday quotients ----------------
    logic [23:0] s6_zb_next, s6_zb_reg;
    logic [48:0] s6_pera;
    logic [6:0]  s6_era_next, s6_era_reg;
    logic [34:0] s6_ph;
    logic [4:0]  s6_hour_next, s6_hour_reg;
    logic [24:0] s6_wb_next, s6_wb_reg;
    logic [50:0] s6_pw;
    logic [21:0] s6_wq_next, s6_wq_reg;
    logic [16:0] s6_sod_reg;

    always_comb begin
        s6_zb_next   = 24'(s5_days_reg) + 24'(Z_BIAS);
        s6_pera      = 49'(s6_zb_next) * 49'(RCP_146097);
        s6_era_next  = s6_pera[48:42];
        s6_ph        = 35'(s5_sod_reg) * 35'(RCP_3600);
        s6_hour_next = s6_ph[33:29];
        s6_wb_next   = {s5_wbase_reg[23], s5_wbase_reg} + 25'(W_BIAS);
        s6_pw        = 51'(s6_wb_next) * 51'(RCP_7);
        s6_wq_next   = s6_pw[49:28];
    end

    // ---------------- stage 7: remainders ----------------
    logic [23:0] s7_dfull;
    logic [16:0] s7_rfull;
    logic [24:0] s7_wfull;
    logic [17:0] s7_doe_next, s7_doe_reg;
    logic [11:0] s7_rh_next, s7_rh_reg;
    logic [2:0]  s7_wday_next, s7_wday_reg;
    logic [6:0]  s7_era_reg;
    logic [4:0]  s7_hour_reg;

    always_comb begin
        s7_dfull     = s6_zb_reg - 24'(s6_era_reg) * 24'(DAYS_PER_ERA);
        s7_doe_next  = s7_dfull[17:0];
        s7_rfull     = s6_sod_reg - 17'(s6_hour_reg) * 17'(SECS_PER_HOUR);
        s7_rh_next   = s7_rfull[11:0];
        s7_wfull     = s6_wb_reg - 25'(s6_wq_reg) * 25'd7;
        s7_wday_next = s7_wfull[2:0];
    end

    // ---------------- stage 8: leap corrections, minute ----------------
    logic [36:0] s8_p1460, s8_p36524;
    logic [24:0] s8_pmin;
    logic [6:0]  s8_q1460_next, s8_q1460_reg;
    logic [2:0]  s8_q36524_next, s8_q36524_reg;
    logic        s8_last_next, s8_last_reg;
    logic [5:0]  s8_min_next, s8_min_reg;
    logic [17:0] s8_doe_reg;
    logic [6:0]  s8_era_reg;
    logic [4:0]  s8_hour_reg;
    logic [11:0] s8_rh_reg;
    logic [2:0]  s8_wday_reg;

    always_comb begin
        s8_p1460       = 37'(s7_doe_reg) * 37'(RCP_1460);
        s8_q1460_next  = s8_p1460[35:29];
        s8_p36524      = 37'(s7_doe_reg) * 37'(RCP_36524);
        s8_q36524_next = s8_p36524[36:34];
        // last day of an era
        s8_last_next   = (s7_doe_reg == 18'(DAYS_PER_ERA - 1));
        s8_pmin        = 25'(s7_rh_reg) * 25'(RCP_60);
        s8_min_next    = s8_pmin[23:18];
    end

    // ---------------- stage 9: year numerator, second ----------------
    logic [17:0] s9_n_next, s9_n_reg;
    logic [11:0] s9_sfull;
    logic [5:0]  s9_sec_next, s9_sec_reg;
    logic [17:0] s9_doe_reg;
    logic [6:0]  s9_era_reg;
    logic [4:0]  s9_hour_reg;
    logic [5:0]  s9_min_reg;
    logic [2:0]  s9_wday_reg;

    always_comb begin
        s9_n_next   = s8_doe_reg - 18'(s8_q1460_reg) + 18'(s8_q36524_reg)
                      - 18'(s8_last_reg);
        s9_sfull    = s8_rh_reg - 12'(s8_min_reg) * 12'd60;
        s9_sec_next = s9_sfull[5:0];
    end

    // ---------------- stage 10: year of era ----------------
    logic [36:0] s10_py;
    logic [8:0]  s10_yoe_next, s10_yoe_reg;
    logic [17:0] s10_doe_reg;
    logic [6:0]  s10_era_reg;
    logic [4:0]  s10_hour_reg;
    logic [5:0]  s10_min_reg, s10_sec_reg;
    logic [2:0]  s10_wday_reg;

    always_comb begin
        s10_py       = 37'(s9_n_reg) * 37'(RCP_365);
        s10_yoe_next = s10_py[35:27];
    end

    // ---------------- stage 11: year start terms, base year ----------------
    logic [17:0]       s11_y365_next, s11_y365_reg;
    logic [18:0]       s11_p100;
    logic [1:0]        s11_q100_next, s11_q100_reg;
    logic signed [7:0] s11_era_s;
    logic [15:0]       s11_ybase_next, s11_ybase_reg;
    logic [8:0]        s11_yoe_reg;
    logic [17:0]       s11_doe_reg;
    logic [4:0]        s11_hour_reg;
    logic [5:0]        s11_min_reg, s11_sec_reg;
    logic [2:0]        s11_wday_reg;

    always_comb begin
        s11_y365_next  = 18'(s10_yoe_reg) * 18'd365;
        s11_p100       = 19'(s10_yoe_reg) * 19'(RCP_100);
        s11_q100_next  = s11_p100[17:16];
        s11_era_s      = signed'(8'(s10_era_reg) - 8'(ERA_BIAS));
        s11_ybase_next = 16'(s11_era_s) * 16'sd400 + 16'(s10_yoe_reg);
    end

    // ---------------- stage 12: day of year from March 1 ----------------
    logic [17:0] s12_dfull;
    logic [8:0]  s12_doy_next, s12_doy_reg;
    logic [8:0]  s12_yoe_reg;
    logic [15:0] s12_ybase_reg;
    logic [4:0]  s12_hour_reg;
    logic [5:0]  s12_min_reg, s12_sec_reg;
    logic [2:0]  s12_wday_reg;

    always_comb begin
        s12_dfull    = s11_doe_reg - s11_y365_reg - 18'(s11_yoe_reg[8:2])
                       + 18'(s11_q100_reg);
        s12_doy_next = s12_dfull[8:0];
    end

    // ---------------- stage 13: shifted month ----------------
    logic [10:0] s13_arg;
    logic [22:0] s13_pmp;
    logic [3:0]  s13_mp_next, s13_mp_reg;
    logic [8:0]  s13_doy_reg, s13_yoe_reg;
    logic [15:0] s13_ybase_reg;
    logic [4:0]  s13_hour_reg;
    logic [5:0]  s13_min_reg, s13_sec_reg;
    logic [2:0]  s13_wday_reg;

    always_comb begin
        s13_arg     = 11'(s12_doy_reg) * 11'd5 + 11'd2;
        s13_pmp     = 23'(s13_arg) * 23'(RCP_153);
        s13_mp_next = s13_pmp[22:19];
    end

    // ---------------- stage 14: calendar fields, output register ----------------
    logic              s14_janfeb;
    logic [8:0]        s14_mday_full, s14_y400;
    logic              s14_leap;
    logic [SEC_W-1:0]   out_sec_reg;
    logic [MIN_W-1:0]   out_min_reg;
    logic [HOUR_W-1:0]  out_hour_reg;
    logic [MDAY_W-1:0]  out_mday_next, out_mday_reg;
    logic [MONTH_W-1:0] out_month_next, out_month_reg;
    logic [YEAR_W-1:0]  out_year_next, out_year_reg;
    logic [YDAY_W-1:0]  out_yday_next, out_yday_reg;
    logic [WDAY_W-1:0]  out_wday_reg;

    always_comb begin
        // March-based months 10 and 11 are January and February of next year
        s14_janfeb     = (s13_mp_reg >= 4'd10);
        out_month_next = s14_janfeb ? s13_mp_reg - 4'd10 : s13_mp_reg + 4'd2;
        s14_mday_full  = s13_doy_reg - mp_start(s13_mp_reg) + 9'd1;
        out_mday_next  = s14_mday_full[4:0];
        // year within the 400-year cycle decides leap
        s14_y400       = s13_yoe_reg + 9'(s14_janfeb);
        s14_leap       = (s14_y400[1:0] == 2'b00) && (s14_y400 != 9'd100)
                         && (s14_y400 != 9'd200) && (s14_y400 != 9'd300);
        out_yday_next  = s14_janfeb ? s13_doy_reg - 9'd306
                                    : s13_doy_reg + 9'd59 + 9'(s14_leap);
        out_year_next  = s13_ybase_reg + 16'(s14_janfeb) - 16'd1900;
    end

    assign m_axis_tdata = OUT_TDATA_W'({out_wday_reg, out_yday_reg, out_year_reg,
                                        out_month_reg, out_mday_reg, out_hour_reg,
                                        out_min_reg, out_sec_reg});

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            s1_t_reg <= s1_t_next;
        end
        if (adv[1]) begin
            s2_x_reg   <= s2_x_next;
            s2_a_reg   <= s2_a_next;
            s2_tl_reg  <= s1_t_reg[22:0];
            s2_neg_reg <= s1_t_reg[40];
        end
        if (adv[2]) begin
            s3_b_reg   <= s3_b_next;
            s3_a_reg   <= s2_a_reg;
            s3_tl_reg  <= s2_tl_reg;
            s3_neg_reg <= s2_neg_reg;
        end
        if (adv[3]) begin
            s4_y_reg   <= s4_y_next;
            s4_c_reg   <= s4_c_next;
            s4_a_reg   <= s3_a_reg;
            s4_tl7_reg <= s3_tl_reg[6:0];
            s4_neg_reg <= s3_neg_reg;
        end
        if (adv[4]) begin
            s5_sod_reg   <= s5_sod_next;
            s5_days_reg  <= s5_days_next;
            s5_wbase_reg <= s5_wbase_next;
        end
        if (adv[5]) begin
            s6_zb_reg   <= s6_zb_next;
            s6_era_reg  <= s6_era_next;
            s6_hour_reg <= s6_hour_next;
            s6_wb_reg   <= s6_wb_next;
            s6_wq_reg   <= s6_wq_next;
            s6_sod_reg  <= s5_sod_reg;
        end
        if (adv[6]) begin
            s7_doe_reg  <= s7_doe_next;
            s7_rh_reg   <= s7_rh_next;
            s7_wday_reg <= s7_wday_next;
            s7_era_reg  <= s6_era_reg;
            s7_hour_reg <= s6_hour_reg;
        end
        if (adv[7]) begin
            s8_q1460_reg  <= s8_q1460_next;
            s8_q36524_reg <= s8_q36524_next;
            s8_last_reg   <= s8_last_next;
            s8_min_reg    <= s8_min_next;
            s8_doe_reg    <= s7_doe_reg;
            s8_era_reg    <= s7_era_reg;
            s8_hour_reg   <= s7_hour_reg;
            s8_rh_reg     <= s7_rh_reg;
            s8_wday_reg   <= s7_wday_reg;
        end
        if (adv[8]) begin
            s9_n_reg    <= s9_n_next;
            s9_sec_reg  <= s9_sec_next;
            s9_doe_reg  <= s8_doe_reg;
            s9_era_reg  <= s8_era_reg;
            s9_hour_reg <= s8_hour_reg;
            s9_min_reg  <= s8_min_reg;
            s9_wday_reg <= s8_wday_reg;
        end
        if (adv[9]) begin
            s10_yoe_reg  <= s10_yoe_next;
            s10_doe_reg  <= s9_doe_reg;
            s10_era_reg  <= s9_era_reg;
            s10_hour_reg <= s9_hour_reg;
            s10_min_reg  <= s9_min_reg;
            s10_sec_reg  <= s9_sec_reg;
            s10_wday_reg <= s9_wday_reg;
        end
        if (adv[10]) begin
            s11_y365_reg  <= s11_y365_next;
            s11_q100_reg  <= s11_q100_next;
            s11_ybase_reg <= s11_ybase_next;
            s11_yoe_reg   <= s10_yoe_reg;
            s11_doe_reg   <= s10_doe_reg;
            s11_hour_reg  <= s10_hour_reg;
            s11_min_reg   <= s10_min_reg;
            s11_sec_reg   <= s10_sec_reg;
            s11_wday_reg  <= s10_wday_reg;
        end
        if (adv[11]) begin
            s12_doy_reg   <= s12_doy_next;
            s12_yoe_reg   <= s11_yoe_reg;
            s12_ybase_reg <= s11_ybase_reg;
            s12_hour_reg  <= s11_hour_reg;
            s12_min_reg   <= s11_min_reg;
            s12_sec_reg   <= s11_sec_reg;
            s12_wday_reg  <= s11_wday_reg;
        end
        if (adv[12]) begin
            s13_mp_reg    <= s13_mp_next;
            s13_doy_reg   <= s12_doy_reg;
            s13_yoe_reg   <= s12_yoe_reg;
            s13_ybase_reg <= s12_ybase_reg;
            s13_hour_reg  <= s12_hour_reg;
            s13_min_reg   <= s12_min_reg;
            s13_sec_reg   <= s12_sec_reg;
            s13_wday_reg  <= s12_wday_reg;
        end
        if (adv[13]) begin
            out_mday_reg  <= out_mday_next;
            out_month_reg <= out_month_next;
            out_year_reg  <= out_year_next;
            out_yday_reg  <= out_yday_next;
            out_hour_reg  <= s13_hour_reg;
            out_min_reg   <= s13_min_reg;
            out_sec_reg   <= s13_sec_reg;
            out_wday_reg  <= s13_wday_reg;
        end
    end

endmodule

FILE: design/ecd_checker.sv
// ecd_checker: port-level checks for epoch_seconds_to_civil_date, bound in below.
// Depends on ecd_pkg for the result field layout.
module ecd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ecd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import ecd_pkg::*;

    logic [SEC_W-1:0]   c_sec;
    logic [MIN_W-1:0]   c_min;
    logic [HOUR_W-1:0]  c_hour;
    logic [MDAY_W-1:0]  c_mday;
    logic [MONTH_W-1:0] c_month;
    logic [YDAY_W-1:0]  c_yday;
    logic [WDAY_W-1:0]  c_wday;

    assign c_sec   = m_axis_tdata[SEC_LSB +: SEC_W];
    assign c_min   = m_axis_tdata[MIN_LSB +: MIN_W];
    assign c_hour  = m_axis_tdata[HOUR_LSB +: HOUR_W];
    assign c_mday  = m_axis_tdata[MDAY_LSB +: MDAY_W];
    assign c_month = m_axis_tdata[MONTH_LSB +: MONTH_W];
    assign c_yday  = m_axis_tdata[YDAY_LSB +: YDAY_W];
    assign c_wday  = m_axis_tdata[WDAY_LSB +: WDAY_W];

    // stalled result keeps its request and data
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // an accepting consumer never blocks the producer side
    a_ready_through: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    a_field_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (c_sec < 6'd60) && (c_min < 6'd60) && (c_hour < 5'd24)
                          && (c_mday != '0) && (c_month < 4'd12)
                          && (c_yday < 9'd366) && (c_wday < 3'd7))
        else $error("result field out of range");

    // January: day of year follows day of month
    a_january: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (c_month == MONTH_JAN) |-> c_yday == 9'(c_mday) - 9'd1)
        else $error("day of year inconsistent in January");

endmodule

bind epoch_seconds_to_civil_date ecd_checker u_ecd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
